>>> design/dmxrgbw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the dmx rgbw fixture controller
package dmxrgbw_pkg;

   localparam int SLOT_CNT_W = 10;
   localparam int ANIM_W     = 10;
   localparam int ADDR_W     = 9;
   localparam int TIMEOUT_W  = 16;
   localparam int STEP_W     = 8;
   localparam int DUTY_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // item kinds
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANIM_STEP     = 2'd2;

   // fallback show modes
   localparam logic [ADDR_W-1:0] MODE_BEAT  = 9'd1;
   localparam logic [ADDR_W-1:0] MODE_ALL   = 9'd2;
   localparam logic [ADDR_W-1:0] MODE_RED   = 9'd3;
   localparam logic [ADDR_W-1:0] MODE_GREEN = 9'd4;
   localparam logic [ADDR_W-1:0] MODE_BLUE  = 9'd5;
   localparam logic [ADDR_W-1:0] MODE_WHITE = 9'd6;
   localparam logic [ADDR_W-1:0] MODE_FADE  = 9'd7;

   // fade phases
   localparam logic [1:0] PHASE_R2B = 2'd0;
   localparam logic [1:0] PHASE_B2G = 2'd1;
   localparam logic [1:0] PHASE_G2R = 2'd2;
   localparam logic [1:0] PHASE_HOLD = 2'd3;

   localparam logic [DUTY_W-1:0]    DUTY_FULL   = 7'd63;
   localparam logic [DUTY_W-1:0]    DUTY_ANIM_W = 7'd64;
   localparam logic [DUTY_W-1:0]    DUTY_RST_R  = 7'd2;
   localparam logic [TIMEOUT_W-1:0] IDLE_MAX    = 16'hFFFF;
   localparam logic [ADDR_W-1:0]    RST_START   = 9'd1;
   localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = 16'd50;
   localparam logic [STEP_W-1:0]    RST_STEP    = 8'd1;
   localparam logic [ANIM_W-1:0]    RST_ANIM_R  = 10'd255;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_data;
      logic       framing_error;
      logic       beat;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] red_duty;
      logic [DUTY_W-1:0] green_duty;
      logic [DUTY_W-1:0] blue_duty;
      logic [DUTY_W-1:0] white_duty;
      logic              dmx_active;
   } rsp_type;

   typedef struct packed {
      logic [DUTY_W-1:0] red;
      logic [DUTY_W-1:0] green;
      logic [DUTY_W-1:0] blue;
      logic [DUTY_W-1:0] white;
   } duty_type;

   typedef struct packed {
      logic              run;
      logic              beat;
      logic [ADDR_W-1:0] mode;
      logic [STEP_W-1:0] step;
   } show_ctl_type;

endpackage

>>> design/dmxrgbw_show.sv
`timescale 1ns / 1ps
// fallback light shows: beat colors, presets and the three-phase fade
module dmxrgbw_show (
   input  logic                     clock,
   input  logic                     reset,
   input  dmxrgbw_pkg::show_ctl_type ctl,
   input  dmxrgbw_pkg::duty_type     duty_cur,
   output dmxrgbw_pkg::duty_type     duty_next
);

   logic [1:0]                       beat_color_ff, beat_color_in;
   logic [1:0]                       phase_ff, phase_in;
   logic [dmxrgbw_pkg::ANIM_W-1:0]   red_ff, red_in;
   logic [dmxrgbw_pkg::ANIM_W-1:0]   green_ff, green_in;
   logic [dmxrgbw_pkg::ANIM_W-1:0]   blue_ff, blue_in;
   logic [dmxrgbw_pkg::ANIM_W-1:0]   step_ext;
   logic [dmxrgbw_pkg::ANIM_W-1:0]   falling;

   function automatic logic [dmxrgbw_pkg::DUTY_W-1:0] half8(
      input logic [dmxrgbw_pkg::ANIM_W-1:0] v);
      return v[7:1];
   endfunction

   assign step_ext = {{(dmxrgbw_pkg::ANIM_W-dmxrgbw_pkg::STEP_W){1'b0}}, ctl.step};

   always_comb begin
      beat_color_in = beat_color_ff;
      phase_in      = phase_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      falling       = '0;
      duty_next     = duty_cur;
      unique case (ctl.mode)
         dmxrgbw_pkg::MODE_BEAT: begin
            if (ctl.beat) begin
               duty_next.red   = (beat_color_ff == 2'd0) ? dmxrgbw_pkg::DUTY_FULL : '0;
               duty_next.green = (beat_color_ff == 2'd1) ? dmxrgbw_pkg::DUTY_FULL : '0;
               duty_next.blue  = (beat_color_ff == 2'd2) ? dmxrgbw_pkg::DUTY_FULL : '0;
               duty_next.white = (beat_color_ff == 2'd3) ? dmxrgbw_pkg::DUTY_FULL : '0;
               beat_color_in   = beat_color_ff + 2'd1;
            end
         end
         dmxrgbw_pkg::MODE_ALL: begin
            duty_next = '{dmxrgbw_pkg::DUTY_FULL, dmxrgbw_pkg::DUTY_FULL,
                          dmxrgbw_pkg::DUTY_FULL, dmxrgbw_pkg::DUTY_FULL};
         end
         dmxrgbw_pkg::MODE_RED:   duty_next = '{dmxrgbw_pkg::DUTY_FULL, '0, '0, '0};
         dmxrgbw_pkg::MODE_GREEN: duty_next = '{'0, dmxrgbw_pkg::DUTY_FULL, '0, '0};
         dmxrgbw_pkg::MODE_BLUE:  duty_next = '{'0, '0, dmxrgbw_pkg::DUTY_FULL, '0};
         dmxrgbw_pkg::MODE_WHITE: duty_next = '{'0, '0, '0, dmxrgbw_pkg::DUTY_FULL};
         dmxrgbw_pkg::MODE_FADE: begin
            unique case (phase_ff)
               dmxrgbw_pkg::PHASE_R2B: begin
                  red_in  = red_ff - step_ext;
                  blue_in = blue_ff + step_ext;
                  falling = red_in;
               end
               dmxrgbw_pkg::PHASE_B2G: begin
                  blue_in  = blue_ff - step_ext;
                  green_in = green_ff + step_ext;
                  falling  = blue_in;
               end
               dmxrgbw_pkg::PHASE_G2R: begin
                  green_in = green_ff - step_ext;
                  red_in   = red_ff + step_ext;
                  falling  = green_in;
               end
               default: ;
            endcase
            if (phase_ff != dmxrgbw_pkg::PHASE_HOLD) begin
               duty_next = '{half8(red_in), half8(green_in), half8(blue_in),
                             dmxrgbw_pkg::DUTY_ANIM_W};
               // falling channel reached zero or went negative
               if (falling == '0 || falling[dmxrgbw_pkg::ANIM_W-1]) begin
                  phase_in = (phase_ff == dmxrgbw_pkg::PHASE_G2R) ?
                             dmxrgbw_pkg::PHASE_R2B : phase_ff + 2'd1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_color_ff <= '0;
         phase_ff      <= dmxrgbw_pkg::PHASE_R2B;
         red_ff        <= dmxrgbw_pkg::RST_ANIM_R;
         green_ff      <= '0;
         blue_ff       <= '0;
      end else if (ctl.run) begin
         beat_color_ff <= beat_color_in;
         phase_ff      <= phase_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
         blue_ff       <= blue_in;
      end
   end

`ifndef SYNTH
   a_phase_never_hold: assert property (@(posedge clock) disable iff (reset)
      phase_ff != dmxrgbw_pkg::PHASE_HOLD)
      else $error("fade phase entered hold code");

   a_idle_no_change: assert property (@(posedge clock) disable iff (reset)
      !ctl.run |=> $stable(red_ff) && $stable(green_ff) && $stable(blue_ff)
                   && $stable(beat_color_ff))
      else $error("show state moved without a fallback tick");

   a_beat_advances: assert property (@(posedge clock) disable iff (reset)
      ctl.run && ctl.beat && ctl.mode == dmxrgbw_pkg::MODE_BEAT
      |=> beat_color_ff == $past(beat_color_ff) + 2'd1)
      else $error("beat color did not advance");
`endif

endmodule

>>> design/dmx_rgbw_fixture_controller.sv
`timescale 1ns / 1ps
// top level: dmx512 slot capture, idle timeout, duty registers and result register
//
// One result per transfer, one transfer per cycle: every item is handled by a
// single layer of logic between the request port and the result register, so
// the block takes a new item each cycle unless the result register is full and
// stalled. Received bytes count slots (a framing error restarts the count) and
// keep the four slots starting at start_address; a tick either shows those slots
// halved as RGBW duty or, after idle_timeout ticks without bytes, runs the
// fallback show picked by start_address. Results show up in the cycle after the
// request transfer.
module dmx_rgbw_fixture_controller #(
   parameter int MAX_SLOTS = 512
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  dmxrgbw_pkg::req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output dmxrgbw_pkg::rsp_type                   rsp_data,
   input  logic                                   csr_we,
   input  logic [dmxrgbw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dmxrgbw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [dmxrgbw_pkg::SLOT_CNT_W-1:0] SLOT_LIMIT =
      dmxrgbw_pkg::SLOT_CNT_W'(MAX_SLOTS);

   logic [dmxrgbw_pkg::ADDR_W-1:0]     start_ff;
   logic [dmxrgbw_pkg::TIMEOUT_W-1:0]  timeout_ff;
   logic [dmxrgbw_pkg::STEP_W-1:0]     step_ff;

   logic [dmxrgbw_pkg::SLOT_CNT_W-1:0] slot_ff, slot_in;
   logic [7:0]                         capture_ff [4];
   logic [dmxrgbw_pkg::TIMEOUT_W-1:0]  idle_ff, idle_in;
   dmxrgbw_pkg::duty_type              duty_ff, duty_in, show_duty;
   dmxrgbw_pkg::show_ctl_type          show_ctl;
   logic                               rsp_valid_ff;
   dmxrgbw_pkg::rsp_type               rsp_ff;

   logic                               req_xfer;
   logic                               active;
   logic [dmxrgbw_pkg::SLOT_CNT_W-1:0] slot_offset;
   logic                               cap_hit;
   logic                               is_byte;
   logic                               is_tick;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign is_byte   = req_data.opcode == dmxrgbw_pkg::OP_BYTE;
   assign is_tick   = req_data.opcode == dmxrgbw_pkg::OP_TICK;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= dmxrgbw_pkg::RST_START;
         timeout_ff <= dmxrgbw_pkg::RST_TIMEOUT;
         step_ff    <= dmxrgbw_pkg::RST_STEP;
      end else if (csr_we) begin
         unique case (csr_index)
            dmxrgbw_pkg::CSR_START_ADDRESS: start_ff   <= csr_wdata[dmxrgbw_pkg::ADDR_W-1:0];
            dmxrgbw_pkg::CSR_IDLE_TIMEOUT:  timeout_ff <= csr_wdata;
            dmxrgbw_pkg::CSR_ANIM_STEP:     step_ff    <= csr_wdata[dmxrgbw_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   assign slot_offset = slot_ff - {1'b0, start_ff};
   assign cap_hit = (slot_ff >= {1'b0, start_ff}) &&
                    (slot_offset < dmxrgbw_pkg::SLOT_CNT_W'(4));

   always_comb begin
      slot_in = slot_ff;
      idle_in = idle_ff;
      if (is_byte) begin
         idle_in = '0;
         if (req_data.framing_error) begin
            slot_in = '0;
         end else if (slot_ff <= SLOT_LIMIT) begin
            slot_in = slot_ff + dmxrgbw_pkg::SLOT_CNT_W'(1);
         end
      end else if (idle_ff != dmxrgbw_pkg::IDLE_MAX) begin
         idle_in = idle_ff + dmxrgbw_pkg::TIMEOUT_W'(1);
      end
   end

   assign active = idle_in < timeout_ff;

   assign show_ctl = '{run:  req_xfer && is_tick && !active,
                       beat: req_data.beat,
                       mode: start_ff,
                       step: step_ff};

   dmxrgbw_show u_show (
      .clock     (clock),
      .reset     (reset),
      .ctl       (show_ctl),
      .duty_cur  (duty_ff),
      .duty_next (show_duty)
   );

   always_comb begin
      duty_in = duty_ff;
      if (is_tick) begin
         if (active) begin
            duty_in = '{capture_ff[0][7:1], capture_ff[1][7:1],
                        capture_ff[2][7:1], capture_ff[3][7:1]};
         end else begin
            duty_in = show_duty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         idle_ff <= dmxrgbw_pkg::IDLE_MAX;
         duty_ff <= '{dmxrgbw_pkg::DUTY_RST_R, '0, '0, '0};
         for (int i = 0; i < 4; i++) begin
            capture_ff[i] <= '0;
         end
      end else if (req_xfer) begin
         slot_ff <= slot_in;
         idle_ff <= idle_in;
         duty_ff <= duty_in;
         if (is_byte && !req_data.framing_error && slot_ff <= SLOT_LIMIT && cap_hit) begin
            capture_ff[slot_offset[1:0]] <= req_data.rx_data;
         end
      end
   end

   // result register, refilled on every request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= '{duty_in.red, duty_in.green, duty_in.blue, duty_in.white, active};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("request transfer gave no result");

   a_byte_keeps_duty: assert property (@(posedge clock) disable iff (reset)
      req_xfer && is_byte |=> $stable(duty_ff))
      else $error("received byte changed the duties");

   a_active_matches: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_ff.dmx_active == (idle_ff < timeout_ff))
      else $error("dmx_active disagrees with idle count");

   a_byte_clears_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer && is_byte |=> idle_ff == '0)
      else $error("idle count not cleared by a byte");
`endif

endmodule

>>> dv/tb_dmx_rgbw_fixture_controller.sv
`timescale 1ns / 1ps
// self-checking testbench for the dmx rgbw fixture controller
module tb_dmx_rgbw_fixture_controller;
   import dmxrgbw_pkg::*;

   localparam int MAX_SLOTS      = 512;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int ITEM_TARGET    = 1950;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dmx_rgbw_fixture_controller #(.MAX_SLOTS(MAX_SLOTS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // fixture state as the testbench sees it
   logic [ADDR_W-1:0]    dmx_start;
   logic [TIMEOUT_W-1:0] idle_limit;
   logic [STEP_W-1:0]    fade_step_size;
   logic [9:0]           slot_idx;
   logic [7:0]           kept_slot [4];
   logic [TIMEOUT_W-1:0] ticks_since_byte;
   logic [1:0]           beat_pick;
   logic [1:0]           fade_phase;
   logic [ANIM_W-1:0]    fade_red, fade_green, fade_blue;
   duty_type             duty_now;

   rsp_type expected_duty_q [$];
   int      mismatches = 0;
   int      items_sent = 0;
   bit      steady = 1'b0;
   bit      hold_request = 1'b0;

   task automatic reset_fixture_state();
      dmx_start        = RST_START;
      idle_limit       = RST_TIMEOUT;
      fade_step_size   = RST_STEP;
      slot_idx         = '0;
      for (int k = 0; k < 4; k++) kept_slot[k] = '0;
      ticks_since_byte = IDLE_MAX;
      beat_pick        = '0;
      fade_phase       = PHASE_R2B;
      fade_red         = RST_ANIM_R;
      fade_green       = '0;
      fade_blue        = '0;
      duty_now         = '0;
      duty_now.red     = DUTY_RST_R;
   endtask

   // advance the fixture by one transfer and return the duties it shows
   function automatic rsp_type predict_fixture(input req_type item);
      rsp_type           res;
      logic              active;
      int                offset;
      logic [ANIM_W-1:0] step10;
      logic [ANIM_W-1:0] falling;
      logic [1:0]        next_phase;
      step10     = {2'b00, fade_step_size};
      falling    = '0;
      next_phase = fade_phase;
      if (item.opcode == OP_BYTE) begin
         ticks_since_byte = '0;
         if (item.framing_error) begin
            slot_idx = '0;
         end else if (int'(slot_idx) <= MAX_SLOTS) begin
            offset = int'(slot_idx) - int'(dmx_start);
            if (offset >= 0 && offset < 4) kept_slot[offset] = item.rx_data;
            slot_idx = slot_idx + 10'd1;
         end
         active = ticks_since_byte < idle_limit;
      end else begin
         if (ticks_since_byte != IDLE_MAX) ticks_since_byte = ticks_since_byte + 1'b1;
         active = ticks_since_byte < idle_limit;
         if (active) begin
            duty_now.red   = kept_slot[0][7:1];
            duty_now.green = kept_slot[1][7:1];
            duty_now.blue  = kept_slot[2][7:1];
            duty_now.white = kept_slot[3][7:1];
         end else begin
            case (dmx_start)
               MODE_BEAT: begin
                  if (item.beat) begin
                     duty_now = '0;
                     case (beat_pick)
                        2'd0: duty_now.red = DUTY_FULL;
                        2'd1: duty_now.green = DUTY_FULL;
                        2'd2: duty_now.blue = DUTY_FULL;
                        default: duty_now.white = DUTY_FULL;
                     endcase
                     beat_pick = beat_pick + 2'd1;
                  end
               end
               MODE_ALL: duty_now = {DUTY_FULL, DUTY_FULL, DUTY_FULL, DUTY_FULL};
               MODE_RED: duty_now = {DUTY_FULL, 7'd0, 7'd0, 7'd0};
               MODE_GREEN: duty_now = {7'd0, DUTY_FULL, 7'd0, 7'd0};
               MODE_BLUE: duty_now = {7'd0, 7'd0, DUTY_FULL, 7'd0};
               MODE_WHITE: duty_now = {7'd0, 7'd0, 7'd0, DUTY_FULL};
               MODE_FADE: begin
                  case (fade_phase)
                     PHASE_R2B: begin
                        fade_red   = fade_red - step10;
                        fade_blue  = fade_blue + step10;
                        falling    = fade_red;
                        next_phase = PHASE_B2G;
                     end
                     PHASE_B2G: begin
                        fade_blue  = fade_blue - step10;
                        fade_green = fade_green + step10;
                        falling    = fade_blue;
                        next_phase = PHASE_G2R;
                     end
                     PHASE_G2R: begin
                        fade_green = fade_green - step10;
                        fade_red   = fade_red + step10;
                        falling    = fade_green;
                        next_phase = PHASE_R2B;
                     end
                     default: ;
                  endcase
                  if (fade_phase != PHASE_HOLD) begin
                     duty_now = {fade_red[7:1], fade_green[7:1], fade_blue[7:1], DUTY_ANIM_W};
                     // falling channel at zero or below as signed 10 bits
                     if (falling == '0 || falling[ANIM_W-1]) fade_phase = next_phase;
                  end
               end
               default: ;
            endcase
         end
      end
      res.red_duty   = duty_now.red;
      res.green_duty = duty_now.green;
      res.blue_duty  = duty_now.blue;
      res.white_duty = duty_now.white;
      res.dmx_active = active;
      return res;
   endfunction

   function automatic req_type rx_byte(input logic [7:0] data, input logic brk);
      req_type item;
      item.opcode        = OP_BYTE;
      item.rx_data       = data;
      item.framing_error = brk;
      item.beat          = 1'($urandom_range(1, 0));
      return item;
   endfunction

   function automatic req_type tick_item(input logic beat);
      req_type item;
      item.opcode        = OP_TICK;
      item.rx_data       = 8'($urandom_range(255, 0));
      item.framing_error = 1'($urandom_range(1, 0));
      item.beat          = beat;
      return item;
   endfunction

   task automatic send_item(input req_type item);
      rsp_type want;
      @(negedge clock);
      while (!steady && $urandom_range(99, 0) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_fixture(item);
      expected_duty_q.push_back(want);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_duty_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_START_ADDRESS: dmx_start = value[ADDR_W-1:0];
         CSR_IDLE_TIMEOUT: idle_limit = value[TIMEOUT_W-1:0];
         CSR_ANIM_STEP: fade_step_size = value[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(tick_item(1'($urandom_range(1, 0))));
   endtask

   // break, start code, then slot bytes
   task automatic send_frame(input int slots);
      send_item(rx_byte(8'($urandom_range(255, 0)), 1'b1));
      send_item(rx_byte(8'($urandom_range(255, 0)), 1'b0));
      repeat (slots) send_item(rx_byte(8'($urandom_range(255, 0)), 1'b0));
   endtask

   task automatic test_reset_state();
      send_item(tick_item(1'b0));
      repeat (5) send_item(tick_item(1'b1));
   endtask

   task automatic test_live_slots();
      send_item(rx_byte(8'h00, 1'b1));
      send_item(rx_byte(8'h00, 1'b0));
      send_item(rx_byte(8'hFF, 1'b0));
      send_item(rx_byte(8'h00, 1'b0));
      send_item(rx_byte(8'hAA, 1'b0));
      send_item(rx_byte(8'h55, 1'b0));
      send_item(tick_item(1'b0));
   endtask

   task automatic test_fallback_presets();
      logic [ADDR_W-1:0] modes [$];
      modes = '{MODE_ALL, MODE_RED, MODE_GREEN, MODE_BLUE, MODE_WHITE, MODE_FADE,
                '0, MODE_FADE + 9'd1};
      write_csr(CSR_IDLE_TIMEOUT, 1);
      foreach (modes[i]) begin
         write_csr(CSR_START_ADDRESS, modes[i]);
         send_item(tick_item(1'b1));
      end
   endtask

   task automatic test_zero_timeout();
      write_csr(CSR_START_ADDRESS, MODE_BEAT);
      write_csr(CSR_IDLE_TIMEOUT, 0);
      send_item(rx_byte(8'h3C, 1'b0));
      send_item(tick_item(1'b1));
   endtask

   // last slots of the universe: capture past slot 512 never lands
   task automatic test_slot_limit();
      write_csr(CSR_START_ADDRESS, 510);
      write_csr(CSR_IDLE_TIMEOUT, 65535);
      send_frame(514);
      send_item(tick_item(1'b0));
      send_frame(1);
      send_item(tick_item(1'b1));
   endtask

   task automatic test_fade_show();
      int steps [3];
      steps = '{255, 37, 1};
      write_csr(CSR_IDLE_TIMEOUT, 1);
      write_csr(CSR_START_ADDRESS, MODE_FADE);
      foreach (steps[i]) begin
         write_csr(CSR_ANIM_STEP, steps[i]);
         send_ticks(40);
      end
   endtask

   task automatic test_input_backpressure();
      write_csr(CSR_START_ADDRESS, 2);
      write_csr(CSR_IDLE_TIMEOUT, 4);
      hold_request = 1'b1;
      repeat (40) begin
         if ($urandom_range(1, 0)) send_ticks(1);
         else send_item(rx_byte(8'($urandom_range(255, 0)), 1'($urandom_range(4, 0) == 0)));
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int phase_no;
      int pick;
      int events;
      int slots;
      int tick_max;
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         steady = (phase_no >= 3 && phase_no < 6);
         wait_drained();
         if ($urandom_range(2, 0) == 0 || phase_no == 0) begin
            pick = $urandom_range(9, 0);
            if (pick < 6) write_csr(CSR_START_ADDRESS, $urandom_range(7, 0));
            else if (pick < 8) write_csr(CSR_START_ADDRESS, $urandom_range(20, 8));
            else if (pick == 8) write_csr(CSR_START_ADDRESS, $urandom_range(1, 0) ? 509 : 0);
            else write_csr(CSR_START_ADDRESS, $urandom_range(509, 0));
         end
         if ($urandom_range(2, 0) == 0 || phase_no == 0) begin
            pick = $urandom_range(9, 0);
            if (pick < 6) write_csr(CSR_IDLE_TIMEOUT, $urandom_range(6, 1));
            else if (pick < 8) write_csr(CSR_IDLE_TIMEOUT, $urandom_range(40, 7));
            else if (pick == 8) write_csr(CSR_IDLE_TIMEOUT, 65535);
            else write_csr(CSR_IDLE_TIMEOUT, 1);
         end
         if ($urandom_range(2, 0) == 0) begin
            pick = $urandom_range(9, 0);
            if (pick < 7) write_csr(CSR_ANIM_STEP, $urandom_range(255, 1));
            else if (pick == 7) write_csr(CSR_ANIM_STEP, 1);
            else if (pick == 8) write_csr(CSR_ANIM_STEP, 255);
            else write_csr(CSR_ANIM_STEP, $urandom_range(8, 1));
         end
         events = $urandom_range(50, 15);
         repeat (events) begin
            pick = $urandom_range(99, 0);
            if (pick < 35) begin
               // frame long enough to reach the kept slots when they are near
               if (dmx_start <= 40) slots = int'(dmx_start) + $urandom_range(8, 0);
               else slots = $urandom_range(30, 0);
               send_frame(slots);
            end else if (pick < 75) begin
               tick_max = (idle_limit < 10) ? int'(idle_limit) + 3 : 12;
               send_ticks($urandom_range(tick_max, 1));
            end else if (pick < 90) begin
               send_item(rx_byte(8'($urandom_range(255, 0)), 1'($urandom_range(5, 0) == 0)));
            end else begin
               // slot bytes with no break in front
               repeat ($urandom_range(5, 1)) send_item(rx_byte(8'($urandom_range(255, 0)), 1'b0));
            end
         end
         phase_no++;
      end
      steady = 1'b0;
   endtask

   // receiver: random stalls, one long hold when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= !steady && ($urandom_range(99, 0) < 36);
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   int quiet_cycles = 0;

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_duty_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_duty_q.pop_front();
               check_field("red_duty", want.red_duty, rsp_data.red_duty);
               check_field("green_duty", want.green_duty, rsp_data.green_duty);
               check_field("blue_duty", want.blue_duty, rsp_data.blue_duty);
               check_field("white_duty", want.white_duty, rsp_data.white_duty);
               check_field("dmx_active", want.dmx_active, rsp_data.dmx_active);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
               $display("simulation failed");
               $finish;
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset_fixture_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_live_slots();
      test_fallback_presets();
      test_zero_timeout();
      test_slot_limit();
      test_fade_show();
      test_input_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/dmxrgbw_pkg.sv
design/dmxrgbw_show.sv
design/dmx_rgbw_fixture_controller.sv
dv/tb_dmx_rgbw_fixture_controller.sv
